// File: hdl/vdm3_pkg.sv
// Package for the 3x3 vector directional median unit.
// Holds fixed-point constants and the payload struct types. No dependencies.
`default_nettype none
package vdm3_pkg;
  localparam int FracBits = 16;
  localparam int WinSize = 9;
  localparam int CompW = FracBits + 4;
  localparam int DistW = FracBits + 5;
  localparam int SumW = FracBits + 8;
  localparam int SqW = 2 * CompW + 2;
  localparam int MagW = 9 + FracBits;
  localparam int PosW = 4;

  typedef struct packed {
    logic [23:0] pix_top_left;
    logic [23:0] pix_top_mid;
    logic [23:0] pix_top_right;
    logic [23:0] pix_mid_left;
    logic [23:0] pix_center;
    logic [23:0] pix_mid_right;
    logic [23:0] pix_bot_left;
    logic [23:0] pix_bot_mid;
    logic [23:0] pix_bot_right;
  } vdm3_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [3:0] winner_position;
  } vdm3_out_t;

  typedef logic [CompW-1:0] comp_t;
  typedef comp_t [2:0] uvec_t;
endpackage
`default_nettype wire

// File: hdl/vdm3_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage.
// Depends on vdm3_pkg for the radicand width.
`default_nettype none
module vdm3_sqrt_pipe (
  input  wire logic                     clk,
  input  wire logic [vdm3_pkg::SqW-1:0] rad_i,
  output logic [vdm3_pkg::SqW/2-1:0]    root_o
);
  import vdm3_pkg::*;
  localparam int Np = SqW / 2;

  logic [SqW-1:0] rad_r  [Np+1];
  logic [Np+1:0]  rem_r  [Np+1];
  logic [Np-1:0]  root_r [Np+1];

  always_comb begin
    rad_r[0]  = rad_i;
    rem_r[0]  = '0;
    root_r[0] = '0;
  end

  for (genvar k = 0; k < Np; k++) begin : g_st
    logic [Np+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {rem_r[k][Np-1:0], rad_r[k][SqW-1-2*k -: 2]};
      trial  = {root_r[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      rad_r[k+1] <= rad_r[k];
      if (rem_sh >= trial) begin
        rem_r[k+1]  <= rem_sh - trial;
        root_r[k+1] <= {root_r[k][Np-2:0], 1'b1};
      end else begin
        rem_r[k+1]  <= rem_sh;
        root_r[k+1] <= {root_r[k][Np-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_r[Np];
endmodule
`default_nettype wire

// File: hdl/vdm3_unit_lane.sv
// One normalization lane: magnitude by pipelined square root, then three
// component divisions by a pipelined restoring divider. Depends on vdm3_pkg.
`default_nettype none
module vdm3_unit_lane (
  input  wire logic        clk,
  input  wire logic [23:0] pix_i,
  output vdm3_pkg::uvec_t  uvec_o
);
  import vdm3_pkg::*;
  localparam int Np = 9 + FracBits;
  localparam int NumW = 8 + 2 * FracBits;
  localparam int Lat = Np;

  // magnitude: radicand S followed by F zero pairs
  logic [17:0] s;
  logic [2*Np-1:0] rad;
  logic [Np-1:0] mag;
  always_comb begin
    s = 18'(pix_i[23:16] * pix_i[23:16]) + 18'(pix_i[15:8] * pix_i[15:8])
      + 18'(pix_i[7:0] * pix_i[7:0]);
    rad = {s, {(2*FracBits){1'b0}}};
  end

  logic [2*Np+1:0] rem_r [Np+1];
  logic [Np-1:0]   root_r [Np+1];
  logic [2*Np-1:0] rad_r [Np+1];
  logic [23:0]     px_r [Lat+1];

  always_comb begin
    rem_r[0] = '0; root_r[0] = '0; rad_r[0] = rad; px_r[0] = pix_i;
  end

  for (genvar k = 0; k < Np; k++) begin : g_sq
    logic [2*Np+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {rem_r[k][2*Np-1:0], rad_r[k][2*Np-1-2*k -: 2]};
      trial  = (2*Np+2)'({root_r[k], 2'b01});
    end
    always_ff @(posedge clk) begin
      rad_r[k+1] <= rad_r[k];
      px_r[k+1]  <= px_r[k];
      if (rem_sh >= trial) begin
        rem_r[k+1]  <= rem_sh - trial;
        root_r[k+1] <= {root_r[k][Np-2:0], 1'b1};
      end else begin
        rem_r[k+1]  <= rem_sh;
        root_r[k+1] <= {root_r[k][Np-2:0], 1'b0};
      end
    end
  end
  assign mag = root_r[Np];

  // division: quotient below 2^(F+1), so F+1 restoring steps
  localparam int Qn = FracBits + 1;
  logic [NumW-1:0] num_r [3][Qn+1];
  logic [Np:0]     prem_r [3][Qn+1];
  logic [Qn-1:0]   quo_r [3][Qn+1];
  logic [Np-1:0]   div_r [Qn+1];
  logic            blk_r [Qn+1];

  always_comb begin
    div_r[0] = mag;
    blk_r[0] = (px_r[Lat] == 24'd0);
  end

  for (genvar c = 0; c < 3; c++) begin : g_d0
    always_comb begin
      num_r[c][0]  = {px_r[Lat][23-8*c -: 8], {(2*FracBits){1'b0}}};
      // upper bits: value below 2^(NumW-Qn) can be preloaded as remainder
      prem_r[c][0] = (Np+1)'(num_r[c][0] >> Qn);
      quo_r[c][0]  = '0;
    end
  end

  for (genvar k = 0; k < Qn; k++) begin : g_dv
    always_ff @(posedge clk) begin
      div_r[k+1] <= div_r[k];
      blk_r[k+1] <= blk_r[k];
    end
    for (genvar c = 0; c < 3; c++) begin : g_c
      logic [Np+1:0] tr;
      always_comb tr = {prem_r[c][k], num_r[c][k][Qn-1-k]};
      always_ff @(posedge clk) begin
        num_r[c][k+1] <= num_r[c][k];
        if (!blk_r[k] && tr >= (Np+2)'(div_r[k])) begin
          prem_r[c][k+1] <= (Np+1)'(tr - (Np+2)'(div_r[k]));
          quo_r[c][k+1]  <= {quo_r[c][k][Qn-2:0], 1'b1};
        end else begin
          prem_r[c][k+1] <= (Np+1)'(tr);
          quo_r[c][k+1]  <= {quo_r[c][k][Qn-2:0], 1'b0};
        end
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_o
    assign uvec_o[c] = blk_r[Qn] ? CompW'(10 << FracBits) : CompW'(quo_r[c][Qn]);
  end
endmodule
`default_nettype wire

// File: hdl/vdm3_dist_lane.sv
// Distance lane: sum of distances from one window vector to all nine.
// Depends on vdm3_pkg and vdm3_sqrt_pipe.
`default_nettype none
module vdm3_dist_lane (
  input  wire logic                      clk,
  input  wire logic [3:0]                self_i,
  input  vdm3_pkg::uvec_t                uv_i [vdm3_pkg::WinSize],
  output logic [vdm3_pkg::SumW-1:0]      sum_o
);
  import vdm3_pkg::*;
  logic [SqW-1:0]  sq_r [WinSize];
  logic [SqW/2-1:0] d [WinSize];
  logic [CompW-1:0] me [3];

  always_comb begin
    for (int c = 0; c < 3; c++) me[c] = uv_i[self_i][c];
  end

  for (genvar q = 0; q < WinSize; q++) begin : g_q
    logic [CompW-1:0] ad [3];
    always_comb begin
      for (int c = 0; c < 3; c++)
        ad[c] = (me[c] > uv_i[q][c]) ? me[c] - uv_i[q][c] : uv_i[q][c] - me[c];
    end
    always_ff @(posedge clk)
      sq_r[q] <= SqW'(ad[0] * ad[0]) + SqW'(ad[1] * ad[1]) + SqW'(ad[2] * ad[2]);
    vdm3_sqrt_pipe u_sq (.clk(clk), .rad_i(sq_r[q]), .root_o(d[q]));
  end

  logic [SumW-1:0] s1_r [3];
  always_ff @(posedge clk) begin
    for (int g = 0; g < 3; g++)
      s1_r[g] <= SumW'(d[3*g]) + SumW'(d[3*g+1]) + SumW'(d[3*g+2]);
    sum_o <= s1_r[0] + s1_r[1] + s1_r[2];
  end
endmodule
`default_nettype wire

// File: hdl/vector_directional_median_3x3_unit.sv
// Top level of the 3x3 vector directional median unit.
// Depends on vdm3_pkg, vdm3_unit_lane, vdm3_dist_lane.
`default_nettype none
// Accepts one 3x3 RGB window per clock (busy is always low) and returns one
// result per window, in order, through the pipelined square root and divider
// in the nine normalization lanes, the nine distance lanes and the final
// compare: the path to the result register holds 25 magnitude root stages,
// 17 divider stages, one squared-difference stage, 21 distance root stages,
// two adder stages and the output register. The receiver cannot stall: every
// result is shown for one cycle with out_valid and is a transfer at the end
// of it.
module vector_directional_median_3x3_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  vdm3_pkg::vdm3_in_t       in_data,
  output logic                     out_valid,
  output vdm3_pkg::vdm3_out_t      out_data
);
  import vdm3_pkg::*;
  localparam int LatUnit = (9 + FracBits) + (FracBits + 1);
  localparam int LatDist = 1 + SqW / 2 + 2;
  localparam int LatAll = LatUnit + LatDist + 1;

  logic [23:0] px [WinSize];
  uvec_t uv [WinSize];
  logic [SumW-1:0] sums [WinSize];

  always_comb begin
    px[0] = in_data.pix_top_left;  px[1] = in_data.pix_top_mid;
    px[2] = in_data.pix_top_right; px[3] = in_data.pix_mid_left;
    px[4] = in_data.pix_center;    px[5] = in_data.pix_mid_right;
    px[6] = in_data.pix_bot_left;  px[7] = in_data.pix_bot_mid;
    px[8] = in_data.pix_bot_right;
  end

  assign busy = 1'b0;

  // normalize each pixel in its own lane
  for (genvar p = 0; p < WinSize; p++) begin : g_u
    vdm3_unit_lane u_unit (.clk(clk), .pix_i(px[p]), .uvec_o(uv[p]));
    vdm3_dist_lane u_dist (.clk(clk), .self_i(4'(p)), .uv_i(uv), .sum_o(sums[p]));
  end

  // delay the raw pixels alongside the lanes
  logic [24*WinSize-1:0] pxd_r [LatAll-1];
  logic [LatAll-2:0] vld_r;
  always_ff @(posedge clk) begin
    pxd_r[0] <= in_data;
    for (int i = 1; i < LatAll - 1; i++) pxd_r[i] <= pxd_r[i-1];
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[LatAll-3:0], start};
  end

  // merge: pick lowest sum, lowest position on ties
  logic [3:0] best;
  logic [SumW-1:0] bsum;
  always_comb begin
    best = '0;
    bsum = sums[0];
    for (int p = 1; p < WinSize; p++) begin
      if (sums[p] < bsum) begin
        bsum = sums[p];
        best = 4'(p);
      end
    end
  end

  logic [24*WinSize-1:0] win;
  logic [23:0] sel;
  assign win = pxd_r[LatAll-2];
  assign sel = win[24*(WinSize-1-best) +: 24];

  always_ff @(posedge clk) begin
    out_data <= {sel, best};
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= vld_r[LatAll-2];
  end
endmodule
`default_nettype wire

// File: dv/vector_directional_median_3x3_unit_tb.sv
// Testbench for the 3x3 vector directional median unit.
// Drives directed and random windows; checks results with typed or model medians.
// Depends on vdm3_pkg and vector_directional_median_3x3_unit.
`timescale 1ns / 1ps
module vector_directional_median_3x3_unit_tb;
  import vdm3_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 50;
  localparam int RandItems = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic busy_seen = 1'b0;
  vdm3_in_t in_data = '0;
  logic out_valid;
  vdm3_out_t out_data;

  vdm3_out_t median_q[$];
  int n_mismatch = 0;
  int n_windows = 0;
  int n_medians = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  vector_directional_median_3x3_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // Exact floor square root, two radicand bits per step.
  function automatic longint unsigned sqrt_floor(input longint unsigned v);
    longint unsigned root, rem, trial;
    root = 0;
    rem = 0;
    for (int k = 31; k >= 0; k--) begin
      rem = (rem << 2) | ((v >> (2 * k)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic vdm3_out_t pick_median(input vdm3_in_t w);
    logic [23:0] px [WinSize];
    longint unsigned dir [WinSize][3];
    longint unsigned mag, s, sq, d, sum, best_sum;
    int best;
    vdm3_out_t r;
    best = 0;
    best_sum = 0;
    for (int p = 0; p < WinSize; p++) begin
      px[p] = w[24 * (WinSize - p) - 1 -: 24];
      s = 0;
      for (int c = 0; c < 3; c++) s += px[p][23 - 8 * c -: 8] * px[p][23 - 8 * c -: 8];
      if (s == 0) begin
        // black has no direction: park it at (10,10,10)
        for (int c = 0; c < 3; c++) dir[p][c] = 64'd10 << FracBits;
      end else begin
        mag = sqrt_floor(s << (2 * FracBits));
        for (int c = 0; c < 3; c++)
          dir[p][c] = (longint'(px[p][23 - 8 * c -: 8]) << (2 * FracBits)) / mag;
      end
    end
    for (int p = 0; p < WinSize; p++) begin
      sum = 0;
      for (int q = 0; q < WinSize; q++) begin
        sq = 0;
        for (int c = 0; c < 3; c++) begin
          d = dir[p][c] > dir[q][c] ? dir[p][c] - dir[q][c] : dir[q][c] - dir[p][c];
          sq += d * d;
        end
        sum += sqrt_floor(sq);
      end
      // strict compare: equal sums keep the lower position
      if (p == 0 || sum < best_sum) begin
        best_sum = sum;
        best = p;
      end
    end
    r.out_red = px[best][23:16];
    r.out_green = px[best][15:8];
    r.out_blue = px[best][7:0];
    r.winner_position = PosW'(best);
    return r;
  endfunction

  // busy only moves at rising edges, so its value at the falling edge is
  // what the next rising edge sees.
  always @(negedge clk) busy_seen <= busy;

  // Hold the window on the port until a transfer, then queue its median.
  task automatic send_window(input vdm3_in_t w, input bit typed, input vdm3_out_t want);
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy_seen);
    median_q.push_back(typed ? want : pick_median(w));
    n_windows++;
  endtask

  // Drop start for a random number of cycles according to the current phase.
  task automatic sender_gap();
    while ($urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      in_data <= {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  24'($urandom)};
      @(posedge clk);
    end
  endtask

  function automatic logic [23:0] rand_pixel();
    logic [23:0] base;
    int k;
    base = 24'($urandom);
    case ($urandom_range(7, 0))
      0: return 24'h0;
      1: return 24'hFFFFFF;
      2: return base & 24'h0F0F0F;           // dim colors, coarse directions
      3: begin                               // one saturated channel
        k = $urandom_range(2, 0);
        return 24'($urandom_range(255, 1)) << (8 * k);
      end
      default: return base;
    endcase
  endfunction

  // In one mode of four, most pixels are one hue scaled, so sums tie or nearly tie.
  function automatic vdm3_in_t rand_window();
    vdm3_in_t w;
    logic [23:0] hue;
    int mode;
    mode = $urandom_range(3, 0);
    hue = 24'($urandom) & 24'h3F3F3F;
    for (int p = 0; p < WinSize; p++) begin
      if (mode == 0 && $urandom_range(3, 0) != 0)
        w[24 * (WinSize - p) - 1 -: 24] = hue * 24'($urandom_range(4, 1));
      else
        w[24 * (WinSize - p) - 1 -: 24] = rand_pixel();
    end
    return w;
  endfunction

  // Check each strobed result against the oldest pending median.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_medians++;
      if (median_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result %h", out_data);
      end else begin
        vdm3_out_t exp_m;
        exp_m = median_q.pop_front();
        if (out_data !== exp_m) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("median mismatch: exp r=%h g=%h b=%h pos=%0d got r=%h g=%h b=%h pos=%0d",
                     exp_m.out_red, exp_m.out_green, exp_m.out_blue, exp_m.winner_position,
                     out_data.out_red, out_data.out_green, out_data.out_blue,
                     out_data.winner_position);
        end
      end
    end
  end

  // Watchdog: count cycles where nothing transfers on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy_seen) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog expired with %0d results pending", median_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  typedef struct {
    vdm3_in_t  w;
    bit        typed;
    vdm3_out_t want;
  } window_row_t;

  window_row_t rows[$];

  initial begin
    int phase_pct [4];
    vdm3_out_t none;
    none = '0;
    phase_pct = '{0, 74, 17, 0};
    // Directed windows; obvious answers typed, the rest predicted.
    rows.push_back('{{9{24'h000000}}, 1, '{8'h00, 8'h00, 8'h00, 4'd0}});
    rows.push_back('{{9{24'hFFFFFF}}, 1, '{8'hFF, 8'hFF, 8'hFF, 4'd0}});
    rows.push_back('{{{4{24'h0}}, 24'hFFFFFF, {4{24'h0}}}, 1, '{8'h00, 8'h00, 8'h00, 4'd0}});
    rows.push_back('{{{4{24'hFF0000}}, 24'h00FF00, {4{24'h0000FF}}}, 0, none});
    rows.push_back('{{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF,
                      24'hFF00FF, 24'hFFFFFF, 24'h000000, 24'h010101}, 0, none});
    rows.push_back('{{{8{24'h102030}}, 24'h000000}, 0, none});
    rows.push_back('{{24'h000000, {8{24'h010000}}}, 0, none});
    rows.push_back('{{24'h010101, 24'h020202, 24'hFEFEFE, 24'h808080, 24'h7F7F7F,
                      24'h404040, 24'h202020, 24'h101010, 24'hFFFFFF}, 0, none});
    rows.push_back('{{24'h000001, 24'h000100, 24'h010000, 24'h0000FF, 24'h00FF00,
                      24'hFF0000, 24'h000080, 24'h008000, 24'h800000}, 0, none});
    rows.push_back('{{24'hAA5500, 24'h55AA00, 24'h0055AA, 24'hAA0055, 24'h00AA55,
                      24'h5500AA, 24'h555555, 24'hAAAAAA, 24'h123456}, 0, none});
    rows.push_back('{{{4{24'h000000}}, {5{24'h204060}}}, 0, none});
    rows.push_back('{{{5{24'h000000}}, {4{24'h204060}}}, 0, none});
    rows.push_back('{{24'hFFFFFE, 24'hFEFFFF, 24'hFFFEFF, 24'h7F0000, 24'h007F00,
                      24'h00007F, 24'hFF8040, 24'h4080FF, 24'h80FF40}, 0, none});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_window(rows[i].w, rows[i].typed, rows[i].want);

    // Random windows across the idling phases; the last phase runs flat out.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      for (int n = 0; n < RandItems / 4; n++) begin
        sender_gap();
        send_window(rand_window(), 1'b0, none);
      end
    end
    start <= 1'b0;

    while (median_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d windows (%0d directed), %0d medians checked, %0d mismatches",
             n_windows, rows.size(), n_medians, n_mismatch);
    if (n_mismatch == 0 && median_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// File: files.f
hdl/vdm3_pkg.sv
hdl/vdm3_sqrt_pipe.sv
hdl/vdm3_unit_lane.sv
hdl/vdm3_dist_lane.sv
hdl/vector_directional_median_3x3_unit.sv
dv/vector_directional_median_3x3_unit_tb.sv
